// ===== rtl/jms_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter package
// Shared types, codes and the marker classification function.
// ----------------------------------------------------------------------------
package jms_pkg;

    // Parser phase, one-hot.
    typedef enum logic [10:0] {
        PH_SOI_HI  = 11'b000_0000_0001,
        PH_SOI_LO  = 11'b000_0000_0010,
        PH_MARK_HI = 11'b000_0000_0100,
        PH_MARK_LO = 11'b000_0000_1000,
        PH_LEN_HI  = 11'b000_0001_0000,
        PH_LEN_LO  = 11'b000_0010_0000,
        PH_PAYLOAD = 11'b000_0100_0000,
        PH_SCAN    = 11'b000_1000_0000,
        PH_SCAN_FF = 11'b001_0000_0000,
        PH_DONE    = 11'b010_0000_0000,
        PH_FAULT   = 11'b100_0000_0000
    } phase_t;

    // Marker classes. The first six are also the section codes on the output.
    typedef enum logic [3:0] {
        SEC_COM  = 4'd0,
        SEC_DHT  = 4'd1,
        SEC_DQT  = 4'd2,
        SEC_SOS  = 4'd3,
        SEC_SOF0 = 4'd4,
        SEC_APP  = 4'd5,
        SEC_SOI  = 4'd6,
        SEC_EOI  = 4'd7,
        SEC_NONE = 4'd8
    } sec_t;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [2:0] ERR_NO_SOI      = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN     = 3'd1;
    localparam logic [2:0] ERR_SECOND_SOI  = 3'd2;
    localparam logic [2:0] ERR_SHORT_LEN   = 3'd3;
    localparam logic [2:0] ERR_SCAN_MARKER = 3'd4;
    localparam logic [2:0] ERR_NONE        = 3'd0;

    localparam logic [15:0] MARKER_COM  = 16'hFFFE;
    localparam logic [15:0] MARKER_DHT  = 16'hFFC4;
    localparam logic [15:0] MARKER_DQT  = 16'hFFDB;
    localparam logic [15:0] MARKER_SOS  = 16'hFFDA;
    localparam logic [15:0] MARKER_SOF0 = 16'hFFC0;
    localparam logic [15:0] MARKER_SOI  = 16'hFFD8;
    localparam logic [15:0] MARKER_EOI  = 16'hFFD9;
    localparam logic [15:0] APP_FIRST   = 16'hFFE0;
    localparam logic [15:0] APP_LAST    = 16'hFFEF;
    localparam logic [7:0]  FILL_BYTE   = 8'hFF;
    localparam logic [15:0] STUFFED     = 16'hFF00;
    localparam logic [15:0] MIN_LENGTH  = 16'd2;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        phase_t      phase;
        logic [7:0]  high_byte;
        logic [15:0] marker;
        logic [15:0] length;
        logic [15:0] bytes_left;
        logic [2:0]  section;
    } parse_state_t;

    // One result item plus its presence flag.
    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [2:0]  section;
        logic [15:0] marker_code;
        logic [15:0] seg_length;
        logic [7:0]  payload_byte;
        logic [2:0]  error_code;
    } result_t;

    function automatic sec_t classify(input logic [15:0] mk);
        sec_t sec;
        case (mk)
            MARKER_COM:  sec = SEC_COM;
            MARKER_DHT:  sec = SEC_DHT;
            MARKER_DQT:  sec = SEC_DQT;
            MARKER_SOS:  sec = SEC_SOS;
            MARKER_SOF0: sec = SEC_SOF0;
            MARKER_SOI:  sec = SEC_SOI;
            MARKER_EOI:  sec = SEC_EOI;
            default:     sec = (mk >= APP_FIRST && mk <= APP_LAST) ? SEC_APP : SEC_NONE;
        endcase
        return sec;
    endfunction

endpackage

// ===== rtl/jpeg_marker_segmenter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter
// Splits a JPEG byte stream into marker segments, headers and payload bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Handshake                    Payload
//   input     in    data_valid / data_stall      data_byte
//   result    out   result_valid / result_stall  kind, section, marker_code,
//                                                seg_length, payload_byte,
//                                                error_code
//
// One byte can be accepted every cycle while the result side does not stall.
// An accepted byte sits in the input register until the step logic updates
// the parser state and loads at most one result item into the output
// register, from which the result is offered. The input register
// advances whenever the output register is empty or is being taken in the
// same cycle, so a stall on the result side reaches data_stall in the same
// cycle.
// Reset returns the parser to the wait for the opening SOI marker and
// empties both registers. After end of image or an error, bytes are still
// accepted and dropped until reset.
//
module jpeg_marker_segmenter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [2:0]  section,
    output logic [15:0] marker_code,
    output logic [15:0] seg_length,
    output logic [7:0]  payload_byte,
    output logic [2:0]  error_code
);

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    jms_pkg::parse_state_t state_reg;
    jms_pkg::parse_state_t state_next;

    // Output register.
    jms_pkg::result_t result_next;
    logic             out_valid_reg;
    logic [1:0]       kind_reg;
    logic [2:0]       section_reg;
    logic [15:0]      marker_reg;
    logic [15:0]      length_reg;
    logic [7:0]       payload_reg;
    logic [2:0]       error_reg;

    logic advance;

    // The byte in the input register is processed when the output slot is
    // free now or frees up at this edge.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign data_stall = in_valid_reg && !advance;

    jms_step u_step (
        .state      (state_reg),
        .data_byte  (in_byte_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!data_stall)
        begin
            in_valid_reg <= data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_valid && !data_stall)
        begin
            in_byte_reg <= data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase      <= jms_pkg::PH_SOI_HI;
            state_reg.high_byte  <= 8'd0;
            state_reg.marker     <= 16'd0;
            state_reg.length     <= 16'd0;
            state_reg.bytes_left <= 16'd0;
            state_reg.section    <= 3'd0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= result_next.valid;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result_next.valid)
        begin
            kind_reg    <= result_next.kind;
            section_reg <= result_next.section;
            marker_reg  <= result_next.marker_code;
            length_reg  <= result_next.seg_length;
            payload_reg <= result_next.payload_byte;
            error_reg   <= result_next.error_code;
        end
    end

    assign result_valid = out_valid_reg;
    assign kind         = kind_reg;
    assign section      = section_reg;
    assign marker_code  = marker_reg;
    assign seg_length   = length_reg;
    assign payload_byte = payload_reg;
    assign error_code   = error_reg;

endmodule

// ===== rtl/jms_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter step logic
// Combinational next-state and result for one input byte.
// ----------------------------------------------------------------------------
module jms_step (
    input  jms_pkg::parse_state_t state,
    input  logic [7:0]            data_byte,
    output jms_pkg::parse_state_t state_next,
    output jms_pkg::result_t      result
);

    logic [15:0]   pair;
    logic [15:0]   mk;
    logic [2:0]    unknown_code;
    jms_pkg::sec_t sec;
    logic [15:0]   left_after;
    logic [15:0]   len_payload;

    assign pair         = {state.high_byte, data_byte};
    assign mk           = (state.phase == jms_pkg::PH_SCAN_FF) ?
                          {jms_pkg::FILL_BYTE, data_byte} : pair;
    assign unknown_code = (state.phase == jms_pkg::PH_SCAN_FF) ?
                          jms_pkg::ERR_SCAN_MARKER : jms_pkg::ERR_UNKNOWN;
    assign sec          = jms_pkg::classify(mk);
    assign left_after   = state.bytes_left - 16'd1;
    assign len_payload  = pair - jms_pkg::MIN_LENGTH;

    always_comb
    begin
        state_next          = state;
        result.valid        = 1'b0;
        result.kind         = jms_pkg::KIND_PAYLOAD;
        result.section      = state.section;
        result.marker_code  = state.marker;
        result.seg_length   = state.length;
        result.payload_byte = data_byte;
        result.error_code   = jms_pkg::ERR_NONE;

        case (state.phase)
            jms_pkg::PH_SOI_HI:
            begin
                state_next.high_byte = data_byte;
                state_next.phase     = jms_pkg::PH_SOI_LO;
            end
            jms_pkg::PH_MARK_HI:
            begin
                state_next.high_byte = data_byte;
                state_next.phase     = jms_pkg::PH_MARK_LO;
            end
            jms_pkg::PH_LEN_HI:
            begin
                state_next.high_byte = data_byte;
                state_next.phase     = jms_pkg::PH_LEN_LO;
            end
            jms_pkg::PH_SOI_LO:
            begin
                if (pair != jms_pkg::MARKER_SOI)
                begin
                    state_next.phase    = jms_pkg::PH_FAULT;
                    result.valid        = 1'b1;
                    result.kind         = jms_pkg::KIND_ERROR;
                    result.marker_code  = pair;
                    result.seg_length   = 16'd0;
                    result.payload_byte = 8'd0;
                    result.error_code   = jms_pkg::ERR_NO_SOI;
                end
                else
                begin
                    state_next.phase = jms_pkg::PH_MARK_HI;
                end
            end
            jms_pkg::PH_MARK_LO,
            jms_pkg::PH_SCAN_FF:
            begin
                if (state.phase == jms_pkg::PH_SCAN_FF && mk == jms_pkg::STUFFED)
                begin
                    // Stuffed zero after a fill byte: pass the fill byte on.
                    state_next.phase    = jms_pkg::PH_SCAN;
                    result.valid        = 1'b1;
                    result.payload_byte = jms_pkg::FILL_BYTE;
                end
                else if (sec == jms_pkg::SEC_NONE || sec == jms_pkg::SEC_SOI)
                begin
                    state_next.phase    = jms_pkg::PH_FAULT;
                    result.valid        = 1'b1;
                    result.kind         = jms_pkg::KIND_ERROR;
                    result.marker_code  = mk;
                    result.seg_length   = 16'd0;
                    result.payload_byte = 8'd0;
                    result.error_code   = (sec == jms_pkg::SEC_SOI) ?
                                          jms_pkg::ERR_SECOND_SOI : unknown_code;
                end
                else if (sec == jms_pkg::SEC_EOI)
                begin
                    state_next.phase    = jms_pkg::PH_DONE;
                    result.valid        = 1'b1;
                    result.kind         = jms_pkg::KIND_END;
                    result.section      = 3'd0;
                    result.marker_code  = mk;
                    result.seg_length   = 16'd0;
                    result.payload_byte = 8'd0;
                end
                else
                begin
                    state_next.marker  = mk;
                    state_next.section = sec[2:0];
                    state_next.phase   = jms_pkg::PH_LEN_HI;
                end
            end
            jms_pkg::PH_LEN_LO:
            begin
                result.valid        = 1'b1;
                result.seg_length   = pair;
                result.payload_byte = 8'd0;
                if (pair < jms_pkg::MIN_LENGTH)
                begin
                    state_next.phase  = jms_pkg::PH_FAULT;
                    result.kind       = jms_pkg::KIND_ERROR;
                    result.error_code = jms_pkg::ERR_SHORT_LEN;
                end
                else
                begin
                    result.kind           = jms_pkg::KIND_HEADER;
                    state_next.length     = pair;
                    state_next.bytes_left = len_payload;
                    if (len_payload == 16'd0)
                        state_next.phase = (state.section == jms_pkg::SEC_SOS[2:0]) ?
                                           jms_pkg::PH_SCAN : jms_pkg::PH_MARK_HI;
                    else
                        state_next.phase = jms_pkg::PH_PAYLOAD;
                end
            end
            jms_pkg::PH_PAYLOAD:
            begin
                result.valid          = 1'b1;
                state_next.bytes_left = left_after;
                if (left_after == 16'd0)
                    state_next.phase = (state.section == jms_pkg::SEC_SOS[2:0]) ?
                                       jms_pkg::PH_SCAN : jms_pkg::PH_MARK_HI;
            end
            jms_pkg::PH_SCAN:
            begin
                if (data_byte == jms_pkg::FILL_BYTE)
                    state_next.phase = jms_pkg::PH_SCAN_FF;
                else
                    result.valid = 1'b1;
            end
            default:
            begin
                // End of image or fault: bytes are dropped until reset.
                state_next = state;
            end
        endcase
    end

endmodule

// ===== rtl/jms_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module jms_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  kind,
    input logic [15:0] marker_code,
    input logic [15:0] seg_length,
    input logic [2:0]  error_code
);

    // A stalled result stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result_valid dropped while stalled");

    // A stalled result keeps its fields.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=>
            $stable(kind) && $stable(marker_code) && $stable(seg_length) &&
            $stable(error_code))
        else $error("result fields changed while stalled");

    // Only error items carry an error code.
    a_error_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != jms_pkg::KIND_ERROR |-> error_code == jms_pkg::ERR_NONE)
        else $error("error code set on a non-error item");

    // End of image always reports the EOI marker with no length.
    a_end_item: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == jms_pkg::KIND_END |->
            marker_code == jms_pkg::MARKER_EOI && seg_length == 16'd0)
        else $error("malformed end of image item");

    // A segment header never declares a length under two.
    a_header_length: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind == jms_pkg::KIND_HEADER |-> seg_length >= jms_pkg::MIN_LENGTH)
        else $error("segment header with short length");

endmodule

bind jpeg_marker_segmenter jms_checker u_jms_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .marker_code  (marker_code),
    .seg_length   (seg_length),
    .error_code   (error_code)
);

// ===== sim/segment_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter checker
// Watches both channels of the segmenter, keeps its own copy of the parser
// state, predicts the result item of every accepted byte and compares each
// accepted result item field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module segment_checker
    import jms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  kind,
    input  logic [2:0]  section,
    input  logic [15:0] marker_code,
    input  logic [15:0] seg_length,
    input  logic [7:0]  payload_byte,
    input  logic [2:0]  error_code,
    output int          fail_count,
    output int          pending
);

    phase_t      ps_phase   = PH_SOI_HI;
    logic [7:0]  ps_high    = '0;
    logic [15:0] ps_marker  = '0;
    logic [15:0] ps_length  = '0;
    logic [15:0] ps_left    = '0;
    logic [2:0]  ps_section = '0;

    // Results still owed by the block, oldest first.
    result_t owed_results[$];

    function automatic sec_t marker_class(input logic [15:0] mk);
        if (mk == MARKER_COM)  return SEC_COM;
        if (mk == MARKER_DHT)  return SEC_DHT;
        if (mk == MARKER_DQT)  return SEC_DQT;
        if (mk == MARKER_SOS)  return SEC_SOS;
        if (mk == MARKER_SOF0) return SEC_SOF0;
        if (mk == MARKER_SOI)  return SEC_SOI;
        if (mk == MARKER_EOI)  return SEC_EOI;
        if (mk >= APP_FIRST && mk <= APP_LAST) return SEC_APP;
        return SEC_NONE;
    endfunction

    task automatic owe(input logic [1:0] k, input logic [2:0] sec, input logic [15:0] mk,
                       input logic [15:0] len, input logic [7:0] pb, input logic [2:0] err);
        result_t r;
        r.valid        = 1'b1;
        r.kind         = k;
        r.section      = sec;
        r.marker_code  = mk;
        r.seg_length   = len;
        r.payload_byte = pb;
        r.error_code   = err;
        owed_results = {owed_results, r};
    endtask

    // Errors keep the section of the last segment and lock the parser.
    task automatic fault(input logic [2:0] code, input logic [15:0] mk, input logic [15:0] len);
        ps_phase = PH_FAULT;
        owe(KIND_ERROR, ps_section, mk, len, 8'h00, code);
    endtask

    task automatic open_marker(input logic [15:0] mk, input logic [2:0] unknown_code);
        sec_t cls;
        cls = marker_class(mk);
        if (cls == SEC_NONE)
            fault(unknown_code, mk, 16'h0000);
        else if (cls == SEC_SOI)
            fault(ERR_SECOND_SOI, mk, 16'h0000);
        else if (cls == SEC_EOI)
        begin
            ps_phase = PH_DONE;
            // End of image always reports section zero.
            owe(KIND_END, '0, mk, 16'h0000, 8'h00, ERR_NONE);
        end
        else
        begin
            ps_marker  = mk;
            ps_section = 3'(cls);
            ps_phase   = PH_LEN_HI;
        end
    endtask

    task automatic close_segment();
        ps_phase = (ps_section == 3'(SEC_SOS)) ? PH_SCAN : PH_MARK_HI;
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [15:0] pair;
        pair = {ps_high, b};
        case (ps_phase)
            PH_SOI_HI:
            begin
                ps_high  = b;
                ps_phase = PH_SOI_LO;
            end
            PH_MARK_HI:
            begin
                ps_high  = b;
                ps_phase = PH_MARK_LO;
            end
            PH_LEN_HI:
            begin
                ps_high  = b;
                ps_phase = PH_LEN_LO;
            end
            PH_SOI_LO:
            begin
                if (pair != MARKER_SOI)
                    fault(ERR_NO_SOI, pair, 16'h0000);
                else
                    ps_phase = PH_MARK_HI;
            end
            PH_MARK_LO:
                open_marker(pair, ERR_UNKNOWN);
            PH_LEN_LO:
            begin
                if (pair < MIN_LENGTH)
                    fault(ERR_SHORT_LEN, ps_marker, pair);
                else
                begin
                    ps_length = pair;
                    ps_left   = pair - MIN_LENGTH;
                    owe(KIND_HEADER, ps_section, ps_marker, pair, 8'h00, ERR_NONE);
                    if (ps_left == 16'h0000)
                        close_segment();
                    else
                        ps_phase = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                ps_left = ps_left - 16'h0001;
                owe(KIND_PAYLOAD, ps_section, ps_marker, ps_length, b, ERR_NONE);
                if (ps_left == 16'h0000)
                    close_segment();
            end
            PH_SCAN:
            begin
                if (b == FILL_BYTE)
                    ps_phase = PH_SCAN_FF;
                else
                    owe(KIND_PAYLOAD, ps_section, ps_marker, ps_length, b, ERR_NONE);
            end
            PH_SCAN_FF:
            begin
                if ({FILL_BYTE, b} == STUFFED)
                begin
                    ps_phase = PH_SCAN;
                    owe(KIND_PAYLOAD, ps_section, ps_marker, ps_length, FILL_BYTE, ERR_NONE);
                end
                else
                    open_marker({FILL_BYTE, b}, ERR_SCAN_MARKER);
            end
            default:
            begin
                // Done or faulted: bytes are dropped.
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            ps_phase   = PH_SOI_HI;
            ps_high    = '0;
            ps_marker  = '0;
            ps_length  = '0;
            ps_left    = '0;
            ps_section = '0;
            owed_results.delete();
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    $error("result item with none expected: kind %0d marker %0h",
                           kind, marker_code);
                    fail_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    check_field("kind", 16'(want.kind), 16'(kind));
                    check_field("section", 16'(want.section), 16'(section));
                    check_field("marker_code", want.marker_code, marker_code);
                    check_field("seg_length", want.seg_length, seg_length);
                    check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
                    check_field("error_code", 16'(want.error_code), 16'(error_code));
                end
            end
            if (data_valid && !data_stall)
                predict_byte(data_byte);
        end
        pending = owed_results.size();
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JPEG marker segmenter testbench
// Feeds one long, mostly well-formed JPEG byte stream through the segmenter
// under random bursts, gaps and output stalls, and lets the checker compare
// every result item with its own prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import jms_pkg::*;

    // Reset is applied once, so the run is a single image. It opens with a
    // short directed stretch, continues with random segments and scan data,
    // and closes with one randomly chosen ending (end of image or an error).
    localparam int STREAM_BYTES    = 600;
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 10;

    logic        clk;
    logic        rst_n;
    logic        data_valid;
    logic        data_stall;
    logic [7:0]  data_byte;
    logic        result_valid;
    logic        result_stall;
    logic [1:0]  kind;
    logic [2:0]  section;
    logic [15:0] marker_code;
    logic [15:0] seg_length;
    logic [7:0]  payload_byte;
    logic [2:0]  error_code;

    int fail_count;
    int pending;
    int bytes_sent  = 0;
    int burst_left  = 0;
    bit in_scan     = 0;

    jpeg_marker_segmenter uut (.*);

    segment_checker u_check (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop in case the block hangs on a handshake.
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Offer one byte and hold it until the block takes it. Each new burst
    // may start with a gap in which valid is low; about a quarter of the
    // bursts start right away, giving stretches with no idling at all.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                data_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        data_valid <= 1'b1;
        data_byte  <= b;
        do
            @(posedge clk);
        while (data_stall);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_pair(input logic [15:0] w);
        send_byte(w[15:8]);
        send_byte(w[7:0]);
    endtask

    // Any segment marker the block knows, with SOS weighted up so that the
    // scan path and its exits are visited often.
    function automatic logic [15:0] pick_marker();
        case ($urandom_range(0, 7))
            0:       return MARKER_COM;
            1:       return MARKER_DHT;
            2:       return MARKER_DQT;
            3:       return MARKER_SOF0;
            4:       return APP_FIRST + 16'($urandom_range(0, 15));
            default: return MARKER_SOS;
        endcase
    endfunction

    // A full segment: marker, length, payload, and for SOS some entropy data.
    // Scan data never ends on a lone FF; every FF in it is stuffed with 00,
    // so the next marker sent is what ends the scan.
    task automatic send_segment(input logic [15:0] mk);
        logic [15:0] len;
        logic [7:0]  b;
        int          scan_len;
        if ($urandom_range(0, 39) == 0)
            len = 16'($urandom_range(256, 300));
        else
            len = 16'($urandom_range(2, 18));
        send_pair(mk);
        send_pair(len);
        repeat (int'(len) - 2) send_byte(8'($urandom_range(0, 255)));
        in_scan = (mk == MARKER_SOS);
        if (in_scan)
        begin
            scan_len = $urandom_range(1, 30);
            repeat (scan_len)
            begin
                b = ($urandom_range(0, 5) == 0) ? FILL_BYTE : 8'($urandom_range(0, 255));
                send_byte(b);
                if (b == FILL_BYTE)
                    send_byte(8'h00);
            end
        end
    endtask

    // Low byte after FF that forms no known marker and is not a stuffing 00.
    function automatic logic [7:0] bad_marker_low();
        logic [7:0] lo;
        case ($urandom_range(0, 2))
            0: lo = 8'hD0 + 8'($urandom_range(0, 7));
            1: lo = FILL_BYTE;
            default:
            begin
                do
                    lo = 8'($urandom_range(1, 255));
                while (lo == 8'hFE || lo == 8'hC4 || lo == 8'hDB || lo == 8'hDA ||
                       lo == 8'hC0 || lo == 8'hD8 || lo == 8'hD9 ||
                       (lo >= 8'hE0 && lo <= 8'hEF));
            end
        endcase
        return lo;
    endfunction

    // The one ending of this run. In a scan an unknown marker is a bad scan
    // marker; outside it, an unknown one, possibly with a high byte not FF.
    task automatic send_ending();
        case ($urandom_range(0, 6))
            0, 1, 2:
                send_pair(MARKER_EOI);
            3:
            begin
                if (!in_scan && $urandom_range(0, 1) == 1)
                begin
                    send_byte(8'($urandom_range(0, 254)));
                    send_byte(8'($urandom_range(0, 255)));
                end
                else
                    send_pair({FILL_BYTE, bad_marker_low()});
            end
            4:
                send_pair(MARKER_SOI);
            5:
            begin
                // Declared length of zero or one.
                send_pair(pick_marker());
                send_pair(16'($urandom_range(0, 1)));
            end
            default:
            begin
                // Force a scan, then end it with a second SOI or a bad marker.
                send_segment(MARKER_SOS);
                if ($urandom_range(0, 1) == 1)
                    send_pair(MARKER_SOI);
                else
                    send_pair({FILL_BYTE, bad_marker_low()});
            end
        endcase
    endtask

    // Receiver: runs of random length in one of several modes (free, held,
    // heavy or light random stalls). Once the stream is well under way it
    // holds off for a long stretch so that both internal registers fill up
    // and data_stall has to rise while the sender keeps offering bytes.
    initial
    begin
        int mode;
        int run;
        bit held_off;
        mode = 0;
        run = 0;
        held_off = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held_off && bytes_sent >= HOLD_OFF_AT)
            begin
                held_off = 1;
                result_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
                run = 0;
            end
            else
            begin
                if (run == 0)
                begin
                    run  = $urandom_range(1, 16);
                    mode = $urandom_range(0, 3);
                end
                case (mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= 1'b1;
                    2:       result_stall <= ($urandom_range(0, 1) == 1);
                    default: result_stall <= ($urandom_range(0, 3) == 0);
                endcase
                run--;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        rst_n      = 1'b0;
        data_valid = 1'b0;
        data_byte  = 8'h00;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed opening: SOI, an APP0 segment whose payload holds both
        // extreme byte values, a DQT with an empty payload, a COM, then an
        // SOS of length two so the scan starts at once, with a plain zero,
        // a stuffed FF and a near-FF data byte.
        send_pair(MARKER_SOI);
        send_pair(APP_FIRST);
        send_pair(16'd4);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_pair(MARKER_DQT);
        send_pair(MIN_LENGTH);
        send_pair(MARKER_COM);
        send_pair(16'd3);
        send_byte(8'hAA);
        send_pair(MARKER_SOS);
        send_pair(MIN_LENGTH);
        send_byte(8'h00);
        send_pair(STUFFED);
        send_byte(8'hFE);
        in_scan = 1;

        // Random segments; the first marker also leaves the directed scan.
        while (bytes_sent < STREAM_BYTES)
            send_segment(pick_marker());

        send_ending();

        // After the ending every byte must be dropped without a result.
        repeat (4) send_byte(8'($urandom_range(0, 255)));
        @(negedge clk);
        data_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jms_pkg.sv
rtl/jms_step.sv
rtl/jpeg_marker_segmenter.sv
rtl/jms_checker.sv
sim/segment_checker.sv
sim/tb_top.sv
